// File: rtl/pmlf_pkg.sv
// ----------------------------------------------------------------------------
// pmlf_pkg
// Shared types and constants of the page map with LRU / FIFO replacement:
// field widths, register indexes, reset values, and the command and status
// words between controller and datapath.
// ----------------------------------------------------------------------------
package pmlf_pkg;

	// field widths
	localparam int VA_W = 32;
	localparam int PS_W = 17;
	localparam int FC_W = 7;
	localparam int PA_W = 32;

	// register indexes (address bits [3:2])
	localparam logic [1:0] REG_PAGE_SIZE      = 2'd0;
	localparam logic [1:0] REG_FRAME_COUNT    = 2'd1;
	localparam logic [1:0] REG_REPLACE_POLICY = 2'd2;

	// register reset values
	localparam logic [PS_W-1:0] PAGE_SIZE_RST   = 17'd4096;
	localparam logic [FC_W-1:0] FRAME_COUNT_RST = 7'd64;
	localparam logic            POLICY_RST      = 1'b0;

	// replacement policies
	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;        // latch address, start divide, reset search
		logic search;      // walk the table one entry a cycle
		logic mul;         // frame times page size
		logic emit;        // register the result word
		logic install;     // write new page at the free slot
		logic ev_read;     // read the oldest entry
		logic ev_cap;      // capture the oldest entry's frame
		logic shift_init;  // set up the move toward the newest slot
		logic shift;       // move entries down one slot
		logic final_wr;    // write the page at the newest slot
	} pmlf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic srch_hit;
		logic srch_miss;
		logic has_free;
		logic shift_done;
	} pmlf_st_t;

endpackage

// File: rtl/pmlf_div.sv
// ----------------------------------------------------------------------------
// pmlf_div
// Restoring divider, one quotient bit per cycle. Splits the virtual address
// into page number (quotient) and offset (remainder).
// ----------------------------------------------------------------------------
module pmlf_div import pmlf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [VA_W-1:0] dividend,
	input  logic [PS_W-1:0] divisor,
	output logic            done,
	output logic [VA_W-1:0] quot,
	output logic [PS_W-1:0] rem
);

	localparam int StepW = $clog2(VA_W + 1);

	logic [StepW-1:0] step_q;
	logic             run_q;
	logic             done_q;
	logic [VA_W-1:0]  quot_q;
	logic [PS_W-1:0]  rem_q;
	logic [PS_W:0]    shifted;
	logic [PS_W+1:0]  diff;
	logic             neg;

	// trial subtract
	assign shifted = {rem_q, quot_q[VA_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign neg     = diff[PS_W+1];

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= StepW'(VA_W);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			step_q <= step_q - StepW'(1);
			if (step_q == StepW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (run_q) begin
			quot_q <= {quot_q[VA_W-2:0], ~neg};
			rem_q  <= neg ? shifted[PS_W-1:0] : diff[PS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// File: rtl/pmlf_dp.sv
// ----------------------------------------------------------------------------
// pmlf_dp
// Datapath: divider, age-ordered table memory of page and frame, search and
// move counters, multiplier and result registers.
// ----------------------------------------------------------------------------
module pmlf_dp import pmlf_pkg::*; #(
	parameter int MAX_FRAMES = 64,
	parameter int ADDR_BITS  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pmlf_cmd_t       cmd,
	output pmlf_st_t        st,
	input  logic            tbl_clear,
	input  logic [VA_W-1:0] virtual_address,
	input  logic [PS_W-1:0] page_size,
	input  logic [FC_W-1:0] frame_count,
	output logic            hit,
	output logic [PA_W-1:0] physical_address
);

	localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int EW = VA_W + FW;
	localparam int PW = FW + PS_W;
	localparam logic [VA_W-1:0] AddrMask =
		(ADDR_BITS >= VA_W) ? {VA_W{1'b1}} : VA_W'((64'd1 << ADDR_BITS) - 64'd1);

	logic [EW-1:0]   mem [MAX_FRAMES];
	logic [EW-1:0]   rd_q;
	logic [CW-1:0]   vc_q;
	logic [CW-1:0]   rd_idx_q;
	logic            srch_pend_q;
	logic [FW-1:0]   cmp_idx_q;
	logic            found_q;
	logic [FW-1:0]   pos_q;
	logic [FW-1:0]   fr_q;
	logic [CW-1:0]   src_q;
	logic [FW-1:0]   wdst_q;
	logic            sh_pend_q;
	logic [PW-1:0]   prod_q;
	logic            hit_q;
	logic [PA_W-1:0] pa_q;

	logic [PS_W-1:0] ps_eff;
	logic [8:0]      fc9;
	logic [CW-1:0]   cnt_eff;
	logic [CW-1:0]   last;
	logic            div_done;
	logic [VA_W-1:0] vp;
	logic [PS_W-1:0] offs;
	logic [VA_W-1:0] rd_tag;
	logic [FW-1:0]   rd_fr;
	logic            tag_eq;
	logic            srch_issue;
	logic            sh_issue;
	logic            rd_en;
	logic [FW-1:0]   rd_addr;
	logic            wr_en;
	logic [FW-1:0]   wr_addr;
	logic [EW-1:0]   wr_data;
	logic [PW:0]     pa_sum;

	// effective page size and frame count
	assign ps_eff = (page_size == '0) ? PS_W'(1) : page_size;
	assign fc9    = {2'b00, frame_count};
	always_comb begin
		if (fc9 == 9'd0) begin
			cnt_eff = CW'(1);
		end else if (fc9 > 9'(MAX_FRAMES)) begin
			cnt_eff = CW'(MAX_FRAMES);
		end else begin
			cnt_eff = CW'(fc9);
		end
	end
	assign last = vc_q - CW'(1);

	// page number and offset, address taken as the word is accepted
	pmlf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (virtual_address & AddrMask),
		.divisor  (ps_eff),
		.done     (div_done),
		.quot     (vp),
		.rem      (offs)
	);

	// table read and write port selection
	assign rd_tag     = rd_q[EW-1:FW];
	assign rd_fr      = rd_q[FW-1:0];
	assign tag_eq     = (rd_tag == vp);
	assign srch_issue = cmd.search && (rd_idx_q < vc_q);
	assign sh_issue   = cmd.shift && (src_q <= last);
	assign rd_en      = srch_issue || cmd.ev_read || sh_issue;

	always_comb begin
		rd_addr = '0;
		if (cmd.search) begin
			rd_addr = rd_idx_q[FW-1:0];
		end else if (cmd.shift) begin
			rd_addr = src_q[FW-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		if (cmd.shift && sh_pend_q) begin
			wr_en   = 1'b1;
			wr_addr = wdst_q;
			wr_data = rd_q;
		end else if (cmd.install) begin
			wr_en   = 1'b1;
			wr_addr = vc_q[FW-1:0];
			wr_data = {vp, vc_q[FW-1:0]};
		end else if (cmd.final_wr) begin
			wr_en   = 1'b1;
			wr_addr = last[FW-1:0];
			wr_data = {vp, fr_q};
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// valid entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= '0;
		end else if (tbl_clear) begin
			vc_q <= '0;
		end else if (cmd.install) begin
			vc_q <= vc_q + CW'(1);
		end
	end

	// search and move control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			srch_pend_q <= 1'b0;
			found_q     <= 1'b0;
			src_q       <= '0;
			sh_pend_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_idx_q    <= '0;
				srch_pend_q <= 1'b0;
				found_q     <= 1'b0;
			end else if (cmd.search) begin
				srch_pend_q <= srch_issue;
				if (srch_issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (srch_pend_q && tag_eq) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.shift_init) begin
				src_q     <= CW'(pos_q) + CW'(1);
				sh_pend_q <= 1'b0;
			end else if (cmd.shift) begin
				sh_pend_q <= sh_issue;
				if (sh_issue) begin
					src_q <= src_q + CW'(1);
				end
			end
		end
	end

	// entry position, frame and write target
	always_ff @(posedge clk) begin
		if (cmd.search) begin
			cmp_idx_q <= rd_idx_q[FW-1:0];
			if (srch_pend_q && tag_eq) begin
				pos_q <= cmp_idx_q;
				fr_q  <= rd_fr;
			end
		end
		if (cmd.ev_cap) begin
			pos_q <= '0;
			fr_q  <= rd_fr;
		end
		if (sh_issue) begin
			wdst_q <= src_q[FW-1:0] - FW'(1);
		end
	end

	// frame times page size
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PW'(fr_q) * PW'(ps_eff);
		end
	end

	// result word
	assign pa_sum = {1'b0, prod_q} + (PW + 1)'(offs);
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hit_q <= found_q;
			pa_q  <= found_q ? PA_W'(pa_sum) : '0;
		end
	end

	assign hit              = hit_q;
	assign physical_address = pa_q;

	// status
	assign st.div_done   = div_done;
	assign st.srch_hit   = cmd.search && srch_pend_q && tag_eq;
	assign st.srch_miss  = cmd.search && !(srch_pend_q && tag_eq) && (rd_idx_q >= vc_q);
	assign st.has_free   = (vc_q < cnt_eff);
	assign st.shift_done = cmd.shift && !sh_pend_q && (src_q > last);

endmodule

// File: rtl/pmlf_ctrl.sv
// ----------------------------------------------------------------------------
// pmlf_ctrl
// Controller: sequences divide, table search, result, and the table update
// (install, evict or move to newest) for one word at a time.
// ----------------------------------------------------------------------------
module pmlf_ctrl import pmlf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      replace_policy,
	input  pmlf_st_t  st,
	output pmlf_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_SEARCH,
		S_MUL,
		S_EMIT_HIT,
		S_MISS,
		S_INSTALL,
		S_EV_READ,
		S_EV_CAP,
		S_SH_INIT,
		S_SHIFT,
		S_FINAL
	} state_t;

	state_t state_q;
	logic   done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (st.div_done) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (st.srch_hit) begin
						state_q <= S_MUL;
					end else if (st.srch_miss) begin
						state_q <= S_MISS;
					end
				end
				S_MUL: begin
					state_q <= S_EMIT_HIT;
				end
				S_EMIT_HIT: begin
					done_q  <= 1'b1;
					state_q <= (replace_policy == POLICY_LRU) ? S_SH_INIT : S_IDLE;
				end
				S_MISS: begin
					done_q  <= 1'b1;
					state_q <= st.has_free ? S_INSTALL : S_EV_READ;
				end
				S_INSTALL: begin
					state_q <= S_IDLE;
				end
				S_EV_READ: begin
					state_q <= S_EV_CAP;
				end
				S_EV_CAP: begin
					state_q <= S_SH_INIT;
				end
				S_SH_INIT: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (st.shift_done) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && start;
		cmd.search     = (state_q == S_SEARCH);
		cmd.mul        = (state_q == S_MUL);
		cmd.emit       = (state_q == S_EMIT_HIT) || (state_q == S_MISS);
		cmd.install    = (state_q == S_INSTALL);
		cmd.ev_read    = (state_q == S_EV_READ);
		cmd.ev_cap     = (state_q == S_EV_CAP);
		cmd.shift_init = (state_q == S_SH_INIT);
		cmd.shift      = (state_q == S_SHIFT);
		cmd.final_wr   = (state_q == S_FINAL);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// File: rtl/page_map_lru_fifo_replace.sv
// ----------------------------------------------------------------------------
// page_map_lru_fifo_replace
// Fully associative page table with LRU or FIFO replacement: translates a
// virtual word address to frame * page_size + offset, installs on a fault.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  request   start, busy                  virtual_address
//  result    done (one-cycle strobe)      hit, physical_address
//  config    psel, penable, pwrite, ...   pwdata / prdata, paddr [3:2] index
//
//  one word at a time: the bit-serial divider, a search through the valid entries in
//  order, the result, then a move of up to MAX_FRAMES - 1 entries at one per cycle.
//  async reset empties the table; any config write to a known register also
//  empties it. no clearing pass; results cannot be stalled
// ----------------------------------------------------------------------------
module page_map_lru_fifo_replace import pmlf_pkg::*; #(
	parameter int MAX_FRAMES = 64,
	parameter int ADDR_BITS  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [VA_W-1:0] virtual_address,
	output logic            done,
	output logic            hit,
	output logic [PA_W-1:0] physical_address,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	logic [PS_W-1:0] page_size_q;
	logic [FC_W-1:0] frame_count_q;
	logic            policy_q;
	logic            cfg_wr;
	logic            tbl_clear;
	logic [1:0]      reg_idx;
	pmlf_cmd_t       cmd;
	pmlf_st_t        st;

	// config register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		tbl_clear = 1'b0;
		if (cfg_wr) begin
			case (reg_idx)
				REG_PAGE_SIZE, REG_FRAME_COUNT, REG_REPLACE_POLICY: tbl_clear = 1'b1;
				default: tbl_clear = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q   <= PAGE_SIZE_RST;
			frame_count_q <= FRAME_COUNT_RST;
			policy_q      <= POLICY_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PAGE_SIZE:      page_size_q   <= pwdata[PS_W-1:0];
				REG_FRAME_COUNT:    frame_count_q <= pwdata[FC_W-1:0];
				REG_REPLACE_POLICY: policy_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			REG_PAGE_SIZE:      prdata = 32'(page_size_q);
			REG_FRAME_COUNT:    prdata = 32'(frame_count_q);
			REG_REPLACE_POLICY: prdata = 32'(policy_q);
			default:            prdata = '0;
		endcase
	end

	// controller
	pmlf_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.replace_policy (policy_q),
		.st             (st),
		.cmd            (cmd),
		.busy           (busy),
		.done           (done)
	);

	// datapath
	pmlf_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.tbl_clear        (tbl_clear),
		.virtual_address  (virtual_address),
		.page_size        (page_size_q),
		.frame_count      (frame_count_q),
		.hit              (hit),
		.physical_address (physical_address)
	);

endmodule
